// ===== rtl/core/state_packet_crc_checker_macros.svh =====
// ----------------------------------------------------------------------------
// State packet CRC checker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef STATE_PACKET_CRC_CHECKER_MACROS_SVH
`define STATE_PACKET_CRC_CHECKER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SPCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SPCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/spcc_pkg.sv =====
// ----------------------------------------------------------------------------
// spcc_pkg
// Types, constants and the CRC-32 byte step shared by the checker modules.
// ----------------------------------------------------------------------------
package spcc_pkg;

  localparam int PACKET_BYTES = 24;
  localparam int CRC_SPAN     = 20;
  localparam int WORD_COUNT   = 5;
  localparam int POS_W        = $clog2(PACKET_BYTES + 1);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2,
    STATUS_DISABLED = 2'd3
  } status_t;

  // One 32-bit word as four little-endian byte lanes.
  typedef logic [3:0][7:0] word_t;

  // Per-datagram record handed from the front to the back.
  typedef struct packed {
    logic                      link_en;
    logic                      short_pkt;
    logic [31:0]               calc_crc;
    word_t                     check;
    logic [WORD_COUNT-1:0][31:0] words;
  } spcc_rec_t;

  // Reflected CRC-32 over one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/spcc_ifs.sv =====
// ----------------------------------------------------------------------------
// spcc channel interfaces
// Valid/ready byte channel into the checker and result channel out of it.
// ----------------------------------------------------------------------------
interface spcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, rx_byte, last_byte, input ready);
  modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface spcc_result_if;
  import spcc_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] cart_position_bits;
  logic [31:0] tilt_angle_bits;
  logic [31:0] cart_velocity_bits;
  logic [31:0] pole_rate_bits;
  logic [31:0] time_stamp_bits;
  logic [31:0] received_check;
  logic [31:0] good_packets;

  modport source (output valid, status, cart_position_bits, tilt_angle_bits,
                  cart_velocity_bits, pole_rate_bits, time_stamp_bits,
                  received_check, good_packets, input ready);
  modport sink   (input valid, status, cart_position_bits, tilt_angle_bits,
                  cart_velocity_bits, pole_rate_bits, time_stamp_bits,
                  received_check, good_packets, output ready);
endinterface

// ===== rtl/core/spcc_front.sv =====
// ----------------------------------------------------------------------------
// spcc_front
// Accept bytes, run the CRC, gather payload and check words, emit a record.
// ----------------------------------------------------------------------------
module spcc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  spcc_byte_if.sink          byte_stream,
  input  logic               q_full,
  output logic               push,
  output spcc_pkg::spcc_rec_t rec
);
  import spcc_pkg::*;

  logic [31:0]                 crc;
  logic [31:0]                 crc_next;
  logic [POS_W-1:0]            pos;
  logic [POS_W-1:0]            pos_next;
  word_t [WORD_COUNT-1:0]      words;
  word_t [WORD_COUNT-1:0]      words_next;
  word_t                       check;
  word_t                       check_next;
  logic                        link_en;
  logic                        accept;

  assign byte_stream.ready = !q_full;
  assign accept            = byte_stream.valid && byte_stream.ready;
  assign push              = accept && byte_stream.last_byte;

  always_comb begin
    crc_next   = crc;
    words_next = words;
    check_next = check;
    pos_next   = pos;
    if (pos < POS_W'(PACKET_BYTES)) begin
      if (pos < POS_W'(CRC_SPAN)) begin
        crc_next = crc_byte(crc, byte_stream.rx_byte);
        words_next[pos[POS_W-1:2]][pos[1:0]] = byte_stream.rx_byte;
      end else begin
        check_next[pos[1:0]] = byte_stream.rx_byte;
      end
      pos_next = pos + 1'b1;
    end
  end

  always_comb begin
    rec.link_en   = link_en;
    rec.short_pkt = pos_next < POS_W'(PACKET_BYTES);
    rec.calc_crc  = ~crc_next;
    rec.check     = check_next;
    rec.words     = words_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_ALL_ONES;
      pos     <= '0;
      link_en <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        link_en <= cfg_wr_data;
      end
      if (accept) begin
        if (byte_stream.last_byte) begin
          crc <= CRC_ALL_ONES;
          pos <= '0;
        end else begin
          crc <= crc_next;
          pos <= pos_next;
        end
      end
    end
  end

  // Every lane is rewritten before a full packet reads it, so no clear here.
  always_ff @(posedge clk) begin
    if (accept && !byte_stream.last_byte) begin
      words <= words_next;
      check <= check_next;
    end
  end

endmodule

// ===== rtl/core/spcc_queue.sv =====
// ----------------------------------------------------------------------------
// spcc_queue
// Short record queue between the front and the back.
// ----------------------------------------------------------------------------
`include "state_packet_crc_checker_macros.svh"

module spcc_queue #(
  parameter int Depth = spcc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  spcc_pkg::spcc_rec_t wr_data,
  input  logic                pop,
  output spcc_pkg::spcc_rec_t rd_data,
  output logic                rd_valid,
  output logic                full
);
  import spcc_pkg::*;

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  spcc_rec_t         mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign full     = count == CountW'(Depth);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SPCC_ASSERT_NOW(a_no_push_when_full, push, !full)
  `SPCC_ASSERT_NOW(a_no_pop_when_empty, pop, rd_valid)
  `SPCC_ASSERT_NEXT(a_count_rises, push && !pop, count == $past(count) + 1'b1)
  `SPCC_ASSERT_NEXT(a_count_falls, pop && !push, count == $past(count) - 1'b1)

endmodule

// ===== rtl/core/spcc_back.sv =====
// ----------------------------------------------------------------------------
// spcc_back
// Classify a record, count good packets and hold the result register.
// ----------------------------------------------------------------------------
module spcc_back (
  input  logic                clk,
  input  logic                rst,
  input  spcc_pkg::spcc_rec_t rec,
  input  logic                rec_valid,
  output logic                pop,
  spcc_result_if.source       result
);
  import spcc_pkg::*;

  status_t     status;
  status_t     status_next;
  logic        out_valid;
  logic        take;
  logic        keep_fields;
  logic [31:0] good;
  logic [31:0] good_next;
  logic [WORD_COUNT-1:0][31:0] words;
  logic [31:0] check;

  always_comb begin
    if (!rec.link_en) begin
      status_next = STATUS_DISABLED;
    end else if (rec.short_pkt) begin
      status_next = STATUS_SHORT;
    end else if (rec.calc_crc != rec.check) begin
      status_next = STATUS_MISMATCH;
    end else begin
      status_next = STATUS_OK;
    end
  end

  assign keep_fields = (status_next == STATUS_OK) || (status_next == STATUS_MISMATCH);
  assign good_next   = good + {31'd0, status_next == STATUS_OK};
  assign take        = !out_valid || result.ready;
  assign pop         = rec_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      good      <= '0;
    end else begin
      if (take) begin
        out_valid <= rec_valid;
      end
      if (pop) begin
        good <= good_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status <= status_next;
      words  <= keep_fields ? rec.words : '0;
      check  <= keep_fields ? rec.check : '0;
    end
  end

  assign result.valid              = out_valid;
  assign result.status             = status;
  assign result.cart_position_bits = words[0];
  assign result.tilt_angle_bits    = words[1];
  assign result.cart_velocity_bits = words[2];
  assign result.pole_rate_bits     = words[3];
  assign result.time_stamp_bits    = words[4];
  assign result.received_check     = check;
  assign result.good_packets       = good;

endmodule

// ===== rtl/core/state_packet_crc_checker.sv =====
// ----------------------------------------------------------------------------
// state_packet_crc_checker
// Checks received state datagrams byte by byte and reports one result each.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream carries one datagram byte per item (rx_byte) with last_byte
//   set on the final byte. One byte is taken per clock while the record
//   queue has room; the per-byte CRC-32 step in the front sets that rate.
//   The first 20 bytes feed the reflected CRC-32 and form five payload
//   words; bytes 20 to 23 are the received CRC; later bytes are dropped.
//   result carries one item per datagram: status, the raw words, the
//   received CRC (both zero for short or disabled frames) and the running
//   count of good packets. It becomes valid once the record has passed
//   through the queue into the result register, when the back is free.
//   cfg_wr_en/cfg_wr_data write link_en; write it only while idle.
//   When the receiver stalls, the result holds in the output register, up
//   to QUEUE_DEPTH further records wait in the queue, and bytes keep
//   flowing until the queue fills. Synchronous rst clears the link flag,
//   the good count, the CRC and byte position, and empties the queue.
// ----------------------------------------------------------------------------
module state_packet_crc_checker #(
  parameter int QUEUE_DEPTH = spcc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  spcc_byte_if.sink     byte_stream,
  spcc_result_if.source result
);
  import spcc_pkg::*;

  // Front to queue: one record per datagram, pushed with the last byte.
  spcc_rec_t rec_in;
  logic      push;
  logic      q_full;

  // Queue to back.
  spcc_rec_t rec_out;
  logic      rec_valid;
  logic      pop;

  // Front: accept bytes, advance CRC and byte position, drop the excess.
  spcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_stream (byte_stream),
    .q_full      (q_full),
    .push        (push),
    .rec         (rec_in)
  );

  // Queue: decouple byte intake from result delivery.
  spcc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (rec_in),
    .pop      (pop),
    .rd_data  (rec_out),
    .rd_valid (rec_valid),
    .full     (q_full)
  );

  // Back: classify, count good packets, hold the result until taken.
  spcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec_out),
    .rec_valid (rec_valid),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== dv/tb_state_packet_crc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_state_packet_crc_checker
// Streams state datagrams into the CRC checker and compares every result
// with a predictor of its own: well-formed frames with random payload, CRC
// errors, short and long frames, and frames while the link is down. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_state_packet_crc_checker;
  import spcc_pkg::*;

  localparam int  HALF_PERIOD   = 6;
  localparam int  RESET_CYCLES  = 5;
  localparam int  SETTLE_CYCLES = 6;       // quiet cycles after the last result
  localparam int  IDLE_PCT      = 29;
  localparam int  BYTE_TARGET   = 760;
  localparam int  FRAME_TARGET  = 32;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  REPORT_LIMIT  = 10;
  localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;

  // One datagram result as it appears on the result channel.
  typedef struct packed {
    status_t     status;
    logic [31:0] cart_position;
    logic [31:0] tilt_angle;
    logic [31:0] cart_velocity;
    logic [31:0] pole_rate;
    logic [31:0] time_stamp;
    logic [31:0] check;
    logic [31:0] good;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  spcc_byte_if   bytes_if ();
  spcc_result_if results_if ();

  state_packet_crc_checker DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_stream (bytes_if),
    .result      (results_if)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the checker's per-datagram registers, the
  // link flag as last written and the good-packet count.
  // --------------------------------------------------------------------------
  logic        link_up      = 1'b0;
  logic [31:0] crc_acc      = 32'hFFFF_FFFF;
  int          byte_cnt     = 0;
  logic [31:0] payload [WORD_COUNT];
  logic [31:0] crc_field    = '0;
  logic [31:0] good_count   = '0;

  frame_result_t pending_results[$];   // expected results, oldest first
  logic [7:0]    frame_bytes[$];       // datagram under construction
  logic          idle_en    = 1'b1;    // clear for a burst with no idling
  int            err_count  = 0;
  int            cycle_cnt  = 0;

  // Reflected CRC-32, one input byte, bit-serial.
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ POLY_REFLECTED) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    crc_acc   = 32'hFFFF_FFFF;
    byte_cnt  = 0;
    crc_field = '0;
    for (int w = 0; w < WORD_COUNT; w++) payload[w] = '0;
  endfunction

  // Fold one accepted byte into the predicted state; on the last byte,
  // queue the result the checker owes for this datagram.
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    frame_result_t exp_res;
    status_t       st;
    logic          carries;
    if (byte_cnt < PACKET_BYTES) begin
      if (byte_cnt < CRC_SPAN) begin
        crc_acc = crc32_step(crc_acc, b);
        payload[byte_cnt / 4][(byte_cnt % 4) * 8 +: 8] = b;
      end else begin
        crc_field[(byte_cnt % 4) * 8 +: 8] = b;
      end
      byte_cnt++;
    end
    if (!last) return;

    // Disabled link wins over length, length over CRC.
    if (!link_up)                              st = STATUS_DISABLED;
    else if (byte_cnt < PACKET_BYTES)          st = STATUS_SHORT;
    else if ((crc_acc ^ 32'hFFFF_FFFF) != crc_field) st = STATUS_MISMATCH;
    else                                       st = STATUS_OK;
    if (st == STATUS_OK) good_count++;

    // Payload and CRC fields only mean something on a full-length frame.
    carries = (st == STATUS_OK) || (st == STATUS_MISMATCH);
    exp_res.status        = st;
    exp_res.cart_position = carries ? payload[0] : '0;
    exp_res.tilt_angle    = carries ? payload[1] : '0;
    exp_res.cart_velocity = carries ? payload[2] : '0;
    exp_res.pole_rate     = carries ? payload[3] : '0;
    exp_res.time_stamp    = carries ? payload[4] : '0;
    exp_res.check         = carries ? crc_field  : '0;
    exp_res.good          = good_count;
    pending_results.push_back(exp_res);
    clear_frame_state();
  endfunction

  // --------------------------------------------------------------------------
  // Result side: drop ready at random, check each accepted item against the
  // oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_result_t got, want;
    if (!rst && results_if.valid && results_if.ready) begin
      got.status        = results_if.status;
      got.cart_position = results_if.cart_position_bits;
      got.tilt_angle    = results_if.tilt_angle_bits;
      got.cart_velocity = results_if.cart_velocity_bits;
      got.pole_rate     = results_if.pole_rate_bits;
      got.time_stamp    = results_if.time_stamp_bits;
      got.check         = results_if.received_check;
      got.good          = results_if.good_packets;
      if (pending_results.size() == 0) begin
        if (err_count < REPORT_LIMIT)
          $display("unexpected result at cycle %0d: status %0d good %0d",
                   cycle_cnt, got.status, got.good);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (err_count < REPORT_LIMIT) begin
            $display("result mismatch at cycle %0d", cycle_cnt);
            $display("  expected st %0d w %h %h %h %h %h crc %h good %0d", want.status,
                     want.cart_position, want.tilt_angle, want.cart_velocity,
                     want.pole_rate, want.time_stamp, want.check, want.good);
            $display("  actual   st %0d w %h %h %h %h %h crc %h good %0d", got.status,
                     got.cart_position, got.tilt_angle, got.cart_velocity,
                     got.pole_rate, got.time_stamp, got.check, got.good);
          end
          err_count++;
        end
      end
    end
    results_if.ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_state_packet_crc_checker failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte side helpers
  // --------------------------------------------------------------------------

  // Offer one byte, idling first at random; return at the accepting edge.
  // Valid stays high so back-to-back bytes need no second assignment.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid     <= 1'b1;
    bytes_if.rx_byte   <= b;
    bytes_if.last_byte <= last;
    do @(posedge clk); while (!bytes_if.ready);
    absorb_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Hold the byte channel until every expected result is out, then let the
  // back end settle.
  task automatic drain_results();
    bytes_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the link flag while the block is idle.
  task automatic set_link(input logic en);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    link_up = en;
  endtask

  // Build a well-formed datagram: 20 payload bytes, then their CRC, LSB first.
  // A fill value below 256 makes every payload byte that value.
  task automatic build_good_frame(input int fill);
    logic [31:0] c;
    frame_bytes.delete();
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < CRC_SPAN; i++) begin
      frame_bytes.push_back(fill < 256 ? fill[7:0] : 8'($urandom_range(0, 255)));
      c = crc32_step(c, frame_bytes[i]);
    end
    c = c ^ 32'hFFFF_FFFF;
    for (int i = 0; i < 4; i++) frame_bytes.push_back(c[i * 8 +: 8]);
  endtask

  task automatic build_short_frame(input int len);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Flip one bit anywhere in the first 24 bytes; CRC-32 catches every
  // single-bit error, so this always gives a mismatch.
  task automatic corrupt_frame();
    int idx;
    idx = $urandom_range(0, PACKET_BYTES - 1);
    frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task automatic pad_frame(input int extra);
    for (int i = 0; i < extra; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Link is down out of reset: a perfect frame and a one-byte frame are refused.
  task automatic test_link_down_after_reset();
    build_good_frame(256);
    send_frame();
    build_short_frame(1);
    send_frame();
  endtask

  // Frames ending early: one byte only, and one byte short of full length.
  task automatic test_short_frames();
    set_link(1'b1);
    build_short_frame(1);
    send_frame();
    build_short_frame(PACKET_BYTES - 1);
    send_frame();
  endtask

  // Good frames at the byte extremes.
  task automatic test_good_extremes();
    build_good_frame(8'h00);
    send_frame();
    build_good_frame(8'hFF);
    send_frame();
  endtask

  task automatic test_crc_mismatch();
    build_good_frame(256);
    corrupt_frame();
    send_frame();
  endtask

  // Bytes past the first 24 must be dropped without touching the check.
  task automatic test_long_frame();
    build_good_frame(256);
    pad_frame(6);
    send_frame();
  endtask

  // Take the link down by a write, then bring it back.
  task automatic test_link_toggle();
    set_link(1'b0);
    build_good_frame(256);
    send_frame();
    set_link(1'b1);
    build_good_frame(256);
    send_frame();
  endtask

  // Mostly well-formed frames with random payload; the rest are CRC errors,
  // short and long frames. Flip the link now and then, drain now and then,
  // and run one burst with no idling on either side.
  task automatic test_random_traffic();
    int sent   = 0;
    int frames = 0;
    int pick;
    while (sent < BYTE_TARGET || frames < FRAME_TARGET) begin
      if (frames > 0 && frames % 16 == 0)
        set_link($urandom_range(0, 99) < 75);
      else if (frames % 15 == 7)
        drain_results();
      idle_en = !(frames >= 10 && frames < 22);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_good_frame(256);
      end else if (pick < 72) begin
        build_good_frame(256);
        corrupt_frame();
      end else if (pick < 88) begin
        build_short_frame($urandom_range(1, PACKET_BYTES - 1));
      end else begin
        build_good_frame(256);
        pad_frame($urandom_range(1, 8));
        if (pick >= 95) corrupt_frame();
      end
      send_frame();
      sent += frame_bytes.size();
      frames++;
    end
    idle_en = 1'b1;
    set_link(1'b1);
    build_good_frame(256);
    send_frame();
  endtask

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    bytes_if.valid     = 1'b0;
    bytes_if.rx_byte   = 8'h00;
    bytes_if.last_byte = 1'b0;
    clear_frame_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_link_down_after_reset();
    test_short_frames();
    test_good_extremes();
    test_crc_mismatch();
    test_long_frame();
    test_link_toggle();
    test_random_traffic();

    drain_results();
    if (err_count == 0) begin
      $display("tb_state_packet_crc_checker passed");
    end else begin
      $display("tb_state_packet_crc_checker failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spcc_pkg.sv
rtl/core/spcc_ifs.sv
rtl/core/spcc_front.sv
rtl/core/spcc_queue.sv
rtl/core/spcc_back.sv
rtl/core/state_packet_crc_checker.sv
dv/tb_state_packet_crc_checker.sv
